// ===== rtl/hhc_pkg.sv =====
package hhc_pkg;

    // Command codes carried on s_axis_tuser
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

    // Run status codes
    localparam int ST_W = 2;
    localparam logic [ST_W-1:0] ST_IDLE      = 2'd0;
    localparam logic [ST_W-1:0] ST_RUN       = 2'd1;
    localparam logic [ST_W-1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [ST_W-1:0] ST_LIMIT     = 2'd3;

    // Fixed field widths
    localparam int FIN_W  = 16;  // fitness as carried on the streams
    localparam int PICK_W = 3;
    localparam int STEP_W = 16;

    // Register port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_STEP_LIMIT = 1'b0;  // word index, paddr[2]
    localparam logic [STEP_W-1:0] STEP_LIMIT_RST = 16'd100;

endpackage

// ===== rtl/hhc_pick.sv =====
// Neighbor bit choice: reduce the pick modulo DIM, then walk cyclically
// to the first bit not yet marked in the tried mask.
module hhc_pick
    import hhc_pkg::*;
#(
    parameter int DIM = 5
) (
    input  logic [PICK_W-1:0]        i_pick,
    input  logic [DIM-1:0]           i_mask,
    output logic [$clog2(DIM)-1:0]   o_bit,
    output logic                     o_all_tried
);

    localparam int BW = $clog2(DIM);

    logic [PICK_W-1:0] pick_mod;
    logic [BW-1:0]     start_bit;
    logic [BW:0]       sum;
    logic [BW-1:0]     idx;

    // pick is narrow: a few compare-and-subtract steps give the remainder
    always_comb begin
        pick_mod = i_pick;
        for (int i = 0; i < 4; i++) begin
            if (pick_mod >= DIM) begin
                pick_mod = pick_mod - PICK_W'(DIM);
            end
        end
    end

    assign start_bit = BW'(pick_mod);

    // Scan from the far end so the nearest untried bit wins
    always_comb begin
        o_bit = start_bit;
        sum   = '0;
        idx   = '0;
        for (int k = DIM - 1; k >= 0; k--) begin
            sum = {1'b0, start_bit} + (BW+1)'(k);
            if (sum >= DIM) begin
                sum = sum - (BW+1)'(DIM);
            end
            idx = sum[BW-1:0];
            if (!i_mask[idx]) begin
                o_bit = idx;
            end
        end
    end

    assign o_all_tried = &i_mask;

endmodule

// ===== rtl/hypercube_hill_climb_unit.sv =====
// Channel   Dir  Handshake                       Contents
// s_axis    in   s_axis_tvalid / s_axis_tready   tuser: cmd; tdata: point, fitness, pick
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: run state after the command
// apb       in   psel, penable, pwrite, pready   step_limit at byte address 0
//
// Throughput is one transaction per cycle while m_axis does not stall; the
// input register and the result register sit around a single pass of logic
// (one fitness table read, two signed compares, the neighbor pick).
// Reset is synchronous, active low: run idle, no global best, step_limit 100.
// The fitness table is not cleared; read only entries that were loaded.
// A stall on m_axis holds the result; one more transaction may enter the
// input register behind it before s_axis_tready drops.
module hypercube_hill_climb_unit
    import hhc_pkg::*;
#(
    parameter int DIM       = 5,
    parameter int FIT_WIDTH = 16,
    localparam int IN_W  = ((DIM + FIN_W + PICK_W + 7) / 8) * 8,
    localparam int OUT_W = ((3 * DIM + FIN_W + 4 + STEP_W + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // [DIM-1:0] point, [DIM+15:DIM] fitness, [DIM+18:DIM+16] pick
    input  logic [IN_W-1:0]    s_axis_tdata,
    // [1:0] cmd
    input  logic [CMD_W-1:0]   s_axis_tuser,

    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // from bit 0 up: current_point, current_fitness, tried_neighbour, improved,
    // run_status, best_point, best_valid, steps_taken
    output logic [OUT_W-1:0]   m_axis_tdata,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int BW     = $clog2(DIM);
    localparam int NPTS   = 1 << DIM;

    // ---------------------------------------------------------------- config
    logic [STEP_W-1:0] r_step_limit;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_STEP_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_limit <= STEP_LIMIT_RST;
        end else if (cfg_wr) begin
            r_step_limit <= pwdata[STEP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_STEP_LIMIT) ? APB_DW'(r_step_limit) : '0;

    // ---------------------------------------------------------- input stage
    logic               r_in_valid;
    logic [CMD_W-1:0]   r_cmd;
    logic [DIM-1:0]     r_point;
    logic [FIN_W-1:0]   r_fit_in;
    logic [PICK_W-1:0]  r_pick;
    logic               r_out_valid;
    logic               advance;
    logic               fire;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign fire          = r_in_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // payload: load only on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd    <= s_axis_tuser;
            r_point  <= s_axis_tdata[DIM-1:0];
            r_fit_in <= s_axis_tdata[DIM+FIN_W-1:DIM];
            r_pick   <= s_axis_tdata[DIM+FIN_W+PICK_W-1:DIM+FIN_W];
        end
    end

    // ------------------------------------------------------------ run state
    logic [FIT_WIDTH-1:0] r_fit_tab [NPTS];
    logic [DIM-1:0]       r_cur_point, n_cur_point;
    logic [FIT_WIDTH-1:0] r_cur_fit,   n_cur_fit;    // shadow of table[cur_point]
    logic [DIM-1:0]       r_mask,      n_mask;
    logic [STEP_W-1:0]    r_steps,     n_steps;
    logic [ST_W-1:0]      r_status,    n_status;
    logic [DIM-1:0]       r_best,      n_best;
    logic [FIT_WIDTH-1:0] r_best_fit,  n_best_fit;   // shadow of table[best]
    logic                 r_best_valid, n_best_valid;

    logic [BW-1:0]        sel_bit;
    logic                 all_tried;
    logic [DIM-1:0]       neighbour;
    logic [DIM-1:0]       rd_addr;
    logic [FIT_WIDTH-1:0] rd_fit;
    logic [FIT_WIDTH-1:0] load_fit;
    logic [STEP_W-1:0]    steps_inc;
    logic                 better;
    logic                 do_finish;
    logic                 tried_en;
    logic                 improved;

    hhc_pick #(
        .DIM (DIM)
    ) u_pick (
        .i_pick      (r_pick),
        .i_mask      (r_mask),
        .o_bit       (sel_bit),
        .o_all_tried (all_tried)
    );

    assign neighbour = r_cur_point ^ (DIM'(1) << sel_bit);
    // one table port: the start point for a start, the neighbor otherwise
    assign rd_addr   = (r_cmd == CMD_START) ? r_point : neighbour;
    assign rd_fit    = r_fit_tab[rd_addr];
    assign load_fit  = FIT_WIDTH'(signed'(r_fit_in));
    assign better    = signed'(rd_fit) > signed'(r_cur_fit);
    assign steps_inc = (r_steps == '1) ? r_steps : r_steps + 1'b1;

    always_comb begin
        n_cur_point  = r_cur_point;
        n_cur_fit    = r_cur_fit;
        n_mask       = r_mask;
        n_steps      = r_steps;
        n_status     = r_status;
        n_best       = r_best;
        n_best_fit   = r_best_fit;
        n_best_valid = r_best_valid;
        do_finish    = 1'b0;
        tried_en     = 1'b0;
        improved     = 1'b0;
        case (r_cmd)
            CMD_LOAD: begin
                // keep the shadows coherent with the table
                if (r_point == r_cur_point) begin
                    n_cur_fit = load_fit;
                end
                if (r_point == r_best) begin
                    n_best_fit = load_fit;
                end
            end
            CMD_START: begin
                n_cur_point = r_point;
                n_cur_fit   = rd_fit;
                n_mask      = '0;
                n_steps     = '0;
                n_status    = ST_RUN;
                if (r_step_limit == '0) begin
                    n_status  = ST_LIMIT;
                    do_finish = 1'b1;
                end
            end
            CMD_STEP: begin
                if (r_status == ST_RUN) begin
                    n_steps = steps_inc;
                    if (all_tried) begin
                        n_status  = ST_EXHAUSTED;
                        do_finish = 1'b1;
                    end else begin
                        tried_en = 1'b1;
                        if (better) begin
                            n_cur_point = neighbour;
                            n_cur_fit   = rd_fit;
                            n_mask      = '0;
                            improved    = 1'b1;
                        end else begin
                            n_mask = r_mask | (DIM'(1) << sel_bit);
                        end
                        if (steps_inc >= r_step_limit) begin
                            n_status  = ST_LIMIT;
                            do_finish = 1'b1;
                        end
                    end
                end
            end
            CMD_CLEAR: begin
                n_best       = '0;
                n_best_valid = 1'b0;
            end
            default: begin
            end
        endcase
        // end of run: promote the final point if the global slot is empty or worse
        if (do_finish && (!r_best_valid || (signed'(n_cur_fit) > signed'(r_best_fit)))) begin
            n_best       = n_cur_point;
            n_best_fit   = n_cur_fit;
            n_best_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_point  <= '0;
            r_mask       <= '0;
            r_steps      <= '0;
            r_status     <= ST_IDLE;
            r_best       <= '0;
            r_best_valid <= 1'b0;
        end else if (fire) begin
            r_cur_point  <= n_cur_point;
            r_mask       <= n_mask;
            r_steps      <= n_steps;
            r_status     <= n_status;
            r_best       <= n_best;
            r_best_valid <= n_best_valid;
        end
    end

    // fitness shadows and the table carry no reset
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_cur_fit  <= n_cur_fit;
            r_best_fit <= n_best_fit;
            if (r_cmd == CMD_LOAD) begin
                r_fit_tab[r_point] <= load_fit;
            end
        end
    end

    // --------------------------------------------------------- result stage
    logic [OUT_W-1:0] r_out_data;
    logic [DIM-1:0]   tried_pt;

    assign tried_pt = tried_en ? neighbour : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= OUT_W'({n_steps, n_best_valid, n_best, n_status, improved,
                                  tried_pt, FIN_W'(signed'(n_cur_fit)), n_cur_point});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/hhc_checker.sv =====
module hhc_checker
    import hhc_pkg::*;
#(
    parameter int DIM       = 5,
    localparam int OUT_W = ((3 * DIM + FIN_W + 4 + STEP_W + 7) / 8) * 8
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [OUT_W-1:0]   m_axis_tdata,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [APB_AW-1:0]  paddr,
    input logic [APB_DW-1:0]  pwdata,
    input logic [APB_DW-1:0]  prdata,
    input logic               pready
);

    localparam int O_TRY  = DIM + FIN_W;
    localparam int O_IMP  = 2 * DIM + FIN_W;
    localparam int O_ST   = O_IMP + 1;
    localparam int O_BEST = O_ST + ST_W;
    localparam int O_BV   = O_BEST + DIM;

    logic [DIM-1:0]  cur_pt;
    logic [DIM-1:0]  try_pt;
    logic [DIM-1:0]  best_pt;
    logic [ST_W-1:0] status;
    logic            imp;
    logic            bvalid;

    assign cur_pt  = m_axis_tdata[DIM-1:0];
    assign try_pt  = m_axis_tdata[O_IMP-1:O_TRY];
    assign imp     = m_axis_tdata[O_IMP];
    assign status  = m_axis_tdata[O_BEST-1:O_ST];
    assign best_pt = m_axis_tdata[O_BV-1:O_BEST];
    assign bvalid  = m_axis_tdata[O_BV];

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // a move lands on the examined neighbor, and only inside a run
    a_improve_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && imp |-> (cur_pt == try_pt) && (status != ST_IDLE))
        else $error("improved step not at tried neighbor");

    // empty global slot reads as point zero
    a_best_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !bvalid |-> best_pt == '0)
        else $error("best point set without valid");

    // step_limit reads back what was written
    a_limit_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && (paddr[2] == REG_STEP_LIMIT))
        ##1 (psel && !pwrite && (paddr[2] == REG_STEP_LIMIT))
        |-> prdata[STEP_W-1:0] == $past(pwdata[STEP_W-1:0]))
        else $error("step_limit readback mismatch");

endmodule

bind hypercube_hill_climb_unit hhc_checker #(
    .DIM       (DIM)
) u_hhc_checker (.*);

// ===== tb/sv/hhc_climb_checker.sv =====
`timescale 1ns / 100ps

module hhc_climb_checker
    import hhc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [23:0]         i_in_data,
    input  logic [CMD_W-1:0]    i_in_cmd,

    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [55:0]         i_out_data,

    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [APB_AW-1:0]   i_paddr,
    input  logic [APB_DW-1:0]   i_pwdata,

    output int                  o_pending,
    output int                  o_errors
);

    localparam int DIM   = 5;
    localparam int NPTS  = 1 << DIM;
    localparam int OUT_W = ((3 * DIM + FIN_W + 4 + STEP_W + 7) / 8) * 8;

    // Packed from the top field down, so current_point lands in bit 0.
    typedef struct packed {
        logic [STEP_W-1:0]        steps_taken;
        logic                     best_valid;
        logic [DIM-1:0]           best_point;
        logic [ST_W-1:0]          run_status;
        logic                     improved;
        logic [DIM-1:0]           tried_neighbour;
        logic signed [FIN_W-1:0]  current_fitness;
        logic [DIM-1:0]           current_point;
    } t_climb_result;

    localparam int RES_W = $bits(t_climb_result);

    logic signed [FIN_W-1:0] fit_tab [NPTS];
    logic [DIM-1:0]          here_pt;
    logic [DIM-1:0]          tried;
    logic [STEP_W-1:0]       steps;
    logic [STEP_W-1:0]       limit;
    logic [ST_W-1:0]         run_st;
    logic [DIM-1:0]          best_pt;
    logic                    best_ok;
    t_climb_result           expected_q [$];
    int                      errs = 0;

    task automatic close_run(input logic [ST_W-1:0] status);
        run_st = status;
        if (!best_ok || fit_tab[here_pt] > fit_tab[best_pt]) begin
            best_pt = here_pt;
            best_ok = 1'b1;
        end
    endtask

    task automatic climb(input logic [CMD_W-1:0] cmd, input logic [23:0] data,
                         output t_climb_result r);
        logic [DIM-1:0]          pt;
        logic signed [FIN_W-1:0] fv;
        int                      flip;
        logic [DIM-1:0]          nb;
        logic                    moved;
        pt    = data[DIM-1:0];
        fv    = data[DIM+FIN_W-1:DIM];
        flip  = int'(data[DIM+FIN_W+PICK_W-1:DIM+FIN_W]) % DIM;
        nb    = '0;
        moved = 1'b0;
        case (cmd)
            CMD_LOAD: begin
                fit_tab[pt] = fv;
            end
            CMD_START: begin
                here_pt = pt;
                tried   = '0;
                steps   = '0;
                run_st  = ST_RUN;
                if (limit == '0)
                    close_run(ST_LIMIT);
            end
            CMD_STEP: begin
                if (run_st == ST_RUN) begin
                    if (steps != '1)
                        steps++;
                    if (&tried) begin
                        close_run(ST_EXHAUSTED);
                    end else begin
                        // walk up from the pick to the first untried position
                        while (tried[flip])
                            flip = (flip + 1) % DIM;
                        nb       = here_pt;
                        nb[flip] = ~nb[flip];
                        if (fit_tab[nb] > fit_tab[here_pt]) begin
                            here_pt = nb;
                            tried   = '0;
                            moved   = 1'b1;
                        end else begin
                            tried[flip] = 1'b1;
                        end
                        if (steps >= limit)
                            close_run(ST_LIMIT);
                    end
                end
            end
            default: begin
                best_pt = '0;
                best_ok = 1'b0;
            end
        endcase
        r.current_point   = here_pt;
        r.current_fitness = fit_tab[here_pt];
        r.tried_neighbour = nb;
        r.improved        = moved;
        r.run_status      = run_st;
        r.best_point      = best_pt;
        r.best_valid      = best_ok;
        r.steps_taken     = steps;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errs++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_climb_result want;
        t_climb_result got;
        if (!i_rst_n) begin
            here_pt = '0;
            tried   = '0;
            steps   = '0;
            run_st  = ST_IDLE;
            best_pt = '0;
            best_ok = 1'b0;
            limit   = STEP_LIMIT_RST;
            expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2] == REG_STEP_LIMIT)
                limit = i_pwdata[STEP_W-1:0];
            if (i_in_valid && i_in_ready) begin
                climb(i_in_cmd, i_in_data, want);
                expected_q.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                got = t_climb_result'(i_out_data[RES_W-1:0]);
                if (expected_q.size() == 0) begin
                    $display("%0t: result with nothing expected: %h", $time, i_out_data);
                    errs++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("current_point", want.current_point, got.current_point);
                    check_field("current_fitness", want.current_fitness,
                                got.current_fitness);
                    check_field("tried_neighbour", want.tried_neighbour,
                                got.tried_neighbour);
                    check_field("improved", want.improved, got.improved);
                    check_field("run_status", want.run_status, got.run_status);
                    check_field("best_point", want.best_point, got.best_point);
                    check_field("best_valid", want.best_valid, got.best_valid);
                    check_field("steps_taken", want.steps_taken, got.steps_taken);
                    check_field("padding", 0, int'(i_out_data[OUT_W-1:RES_W]));
                end
            end
        end
        o_pending <= expected_q.size();
        o_errors  <= errs;
    end

endmodule

// ===== tb/sv/hypercube_hill_climb_unit_tb.sv =====
`timescale 1ns / 100ps

module hypercube_hill_climb_unit_tb
    import hhc_pkg::*;
();

    localparam int DIM   = 5;
    localparam int NPTS  = 1 << DIM;
    localparam int IN_W  = ((DIM + FIN_W + PICK_W + 7) / 8) * 8;
    localparam int OUT_W = ((3 * DIM + FIN_W + 4 + STEP_W + 7) / 8) * 8;

    // Bound on the whole run.
    localparam int CYCLE_LIMIT = 200000;
    // Long receiver hold, far past what the two-entry pipe can absorb.
    localparam int LONG_STALL  = 300;
    // Margin after the last result before touching the register.
    localparam int TAIL        = 8;

    localparam logic [APB_AW-1:0] STEP_LIMIT_ADDR = {REG_STEP_LIMIT, 2'b00};
    localparam logic [FIN_W-1:0]  FIT_TOP         = 16'h7FFF;
    localparam logic [FIN_W-1:0]  FIT_BOTTOM      = 16'h8000;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;

    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    // [4:0] point, [20:5] fitness, [23:21] pick
    logic [IN_W-1:0]    s_axis_tdata  = '0;
    // [1:0] cmd
    logic [CMD_W-1:0]   s_axis_tuser  = CMD_LOAD;

    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // [4:0] current_point, [20:5] current_fitness, [25:21] tried_neighbour,
    // [26] improved, [28:27] run_status, [33:29] best_point, [34] best_valid,
    // [50:35] steps_taken, [55:51] zero
    logic [OUT_W-1:0]   m_axis_tdata;

    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [APB_AW-1:0]  paddr         = '0;
    logic [APB_DW-1:0]  pwdata        = '0;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    // Idle odds for the two sides, in percent per cycle.
    int tx_idle_pct = 14;
    int rx_idle_pct = 61;

    // Long receiver holds: the stimulus asks, the receiver process counts.
    int stall_asked = 0;
    int stall_given = 0;
    int stall_left  = 0;

    int pending;
    int fails;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    hypercube_hill_climb_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    hhc_climb_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (s_axis_tvalid),
        .i_in_ready     (s_axis_tready),
        .i_in_data      (s_axis_tdata),
        .i_in_cmd       (s_axis_tuser),
        .i_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .i_out_data     (m_axis_tdata),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_pending      (pending),
        .o_errors       (fails)
    );

    // Receiver: honor a pending long hold first, otherwise drop ready at random.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (stall_asked != stall_given) begin
            m_axis_tready <= 1'b0;
            stall_left    <= LONG_STALL;
            stall_given   <= stall_given + 1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Offer one command, idling first at the sender's odds; return once the
    // transaction is taken. Valid stays high so back-to-back items need no gap.
    task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [DIM-1:0] pt,
                            input logic [FIN_W-1:0] fv, input logic [PICK_W-1:0] pk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {pk, fv, pt};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Setup cycle, then access cycle; the write lands when pready is seen high.
    task automatic write_limit(input logic [STEP_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= STEP_LIMIT_ADDR;
        pwdata  <= APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe go quiet.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL) @(posedge i_clk);
    endtask

    // Half full-range values, half a narrow band around zero so that ties
    // and local peaks (and with them exhausted runs) show up often.
    function automatic logic [FIN_W-1:0] rand_fit();
        if ($urandom_range(0, 1))
            return FIN_W'($urandom);
        return FIN_W'($urandom_range(0, 6)) - FIN_W'(3);
    endfunction

    // Mostly complete runs (start then a burst of steps with random picks),
    // with loads mixed in, clears, and a share of plain noise.
    task automatic climb_traffic(input int n_items);
        int sent;
        int burst;
        int r;
        bit held;
        bit paused;
        sent   = 0;
        held   = 1'b0;
        paused = 1'b0;
        while (sent < n_items) begin
            // Hold the receiver off while the sender keeps offering.
            if (!held && sent >= n_items / 3) begin
                stall_asked++;
                held = 1'b1;
            end
            // Pause the sender until everything has come back.
            if (!paused && sent >= (2 * n_items) / 3) begin
                settle();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 6) begin
                push_cmd(CMD_W'($urandom_range(0, 3)), DIM'($urandom), FIN_W'($urandom),
                         PICK_W'($urandom));
                sent++;
            end else if (r < 14) begin
                push_cmd(CMD_LOAD, DIM'($urandom), rand_fit(), PICK_W'($urandom));
                sent++;
            end else if (r < 17) begin
                push_cmd(CMD_CLEAR, DIM'($urandom), FIN_W'($urandom), PICK_W'($urandom));
                sent++;
            end else begin
                push_cmd(CMD_START, DIM'($urandom), FIN_W'($urandom), PICK_W'($urandom));
                sent++;
                burst = $urandom_range(1, 14);
                repeat (burst) begin
                    if ($urandom_range(0, 9) == 0)
                        push_cmd(CMD_LOAD, DIM'($urandom), rand_fit(), PICK_W'($urandom));
                    else
                        push_cmd(CMD_STEP, DIM'($urandom), FIN_W'($urandom),
                                 PICK_W'($urandom_range(0, 7)));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        logic [FIN_W-1:0] fv;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Load every point before any read: point 31 holds the unique maximum,
        // point 0 the minimum, the rest random below the maximum.
        for (int p = 0; p < NPTS; p++) begin
            fv = FIN_W'($urandom_range(0, 65534));
            if (fv == FIT_TOP)
                fv = '0;
            if (p == NPTS - 1)
                fv = FIT_TOP;
            else if (p == 0)
                fv = FIT_BOTTOM;
            push_cmd(CMD_LOAD, DIM'(p), fv, PICK_W'($urandom));
        end

        // Step limit at its reset value in this section.
        push_cmd(CMD_STEP, '0, '0, '0);                 // step while idle: ignored
        push_cmd(CMD_START, DIM'(NPTS - 1), '0, '0);    // start on the peak
        // Repeated picks fall through to the next untried position; pick 7 wraps.
        push_cmd(CMD_STEP, '0, '0, 3'd4);
        push_cmd(CMD_STEP, '0, '0, 3'd4);
        push_cmd(CMD_STEP, '0, '0, 3'd4);
        push_cmd(CMD_STEP, '0, '0, 3'd7);
        push_cmd(CMD_STEP, '0, '0, 3'd0);
        push_cmd(CMD_STEP, '1, '1, 3'd1);               // all five tried: exhausted
        push_cmd(CMD_CLEAR, '1, '1, '1);
        push_cmd(CMD_STEP, '0, '0, 3'd2);               // run over: ignored
        push_cmd(CMD_START, '0, '1, '0);                // start in the valley
        push_cmd(CMD_STEP, '0, '0, 3'd3);
        push_cmd(CMD_LOAD, DIM'(1), FIN_W'($urandom), '0);  // load during a run
        push_cmd(CMD_STEP, '0, '0, 3'd6);
        push_cmd(CMD_START, DIM'(5), '0, '0);           // abandon the running climb
        push_cmd(CMD_STEP, '0, '0, 3'd5);
        settle();

        // Zero limit: a start ends at once and still updates the best.
        write_limit('0);
        push_cmd(CMD_START, DIM'(3), '0, '0);
        push_cmd(CMD_STEP, '0, '0, 3'd1);
        push_cmd(CMD_START, DIM'(NPTS - 1), '0, '0);
        settle();

        // Lower the limit under a live run; the next step must end it.
        write_limit(STEP_LIMIT_RST);
        push_cmd(CMD_START, '0, '0, '0);
        push_cmd(CMD_STEP, '0, '0, 3'd0);
        push_cmd(CMD_STEP, '0, '0, 3'd1);
        push_cmd(CMD_STEP, '0, '0, 3'd2);
        settle();
        write_limit(STEP_W'(1));
        push_cmd(CMD_STEP, '0, '0, 3'd3);
        settle();

        // Random traffic: sender light and receiver heavy idling first.
        write_limit(STEP_W'(12));
        climb_traffic(400);
        settle();

        // Swap the idle odds; the top limit leaves only exhaustion to end runs.
        tx_idle_pct = 61;
        rx_idle_pct = 14;
        write_limit('1);
        climb_traffic(400);
        settle();

        // Full rate on both sides with a short limit.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_limit(STEP_W'(3));
        climb_traffic(400);
        settle();

        if (fails == 0)
            $display("** hypercube_hill_climb_unit: PASSED **");
        else
            $display("** hypercube_hill_climb_unit: FAILED **");
        $finish;
    end

    initial begin : watchdog
        int cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("** hypercube_hill_climb_unit: FAILED **");
        $finish;
    end

endmodule
